@@ src/irec_pkg.sv @@
package irec_pkg;

  // Timer and buffer geometry.
  localparam int TIMER_BITS = 16;
  localparam int MAX_STRING = 11;
  localparam int MAX_BITS = 16;

  // Field widths of the ports.
  localparam int BITCNT_W = 5;
  localparam int CHAR_W = 8;
  localparam int KIND_W = 3;
  localparam int COUNT_W = 4;
  localparam int PHASE_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  // Event kinds carried on event_kind.
  localparam logic [KIND_W-1:0] EV_LONE = 3'd0;
  localparam logic [KIND_W-1:0] EV_STR_START = 3'd1;
  localparam logic [KIND_W-1:0] EV_STR_CHAR = 3'd2;
  localparam logic [KIND_W-1:0] EV_STR_END = 3'd3;
  localparam logic [KIND_W-1:0] EV_OVERFLOW = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_CODE = 2'd2;

  // Register reset values.
  localparam logic [BITCNT_W-1:0] BIT_COUNT_RST = 5'd8;
  localparam logic [CHAR_W-1:0] START_CODE_RST = 8'd2;
  localparam logic [CHAR_W-1:0] END_CODE_RST = 8'd3;

  // Framing result handed from the framer to the output register.
  typedef struct packed {
    logic                valid;
    logic [KIND_W-1:0]   kind;
    logic [CHAR_W-1:0]   value;
    logic [COUNT_W-1:0]  index;
    logic [COUNT_W-1:0]  length;
  } frame_res_t;

endpackage

@@ src/irec_framer.sv @@
module irec_framer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           strobe,
  input  logic [irec_pkg::CHAR_W-1:0]    ch,
  input  logic [irec_pkg::CHAR_W-1:0]    start_code,
  input  logic [irec_pkg::CHAR_W-1:0]    end_code,
  output irec_pkg::frame_res_t           res
);

  logic                          in_string;
  logic                          in_string_next;
  logic [irec_pkg::COUNT_W-1:0]  string_count;
  logic [irec_pkg::COUNT_W-1:0]  string_count_next;
  logic                          full;

  assign full = (string_count >= irec_pkg::COUNT_W'(irec_pkg::MAX_STRING));

  // Classify the character against the string framing state.
  always_comb begin
    res = '0;
    res.value = ch;
    in_string_next = in_string;
    string_count_next = string_count;
    if (strobe) begin
      priority if (ch == start_code) begin
        res.valid = 1'b1;
        res.kind = irec_pkg::EV_STR_START;
        in_string_next = 1'b1;
        string_count_next = '0;
      end else if (ch == end_code) begin
        if (in_string) begin
          res.valid = 1'b1;
          res.kind = irec_pkg::EV_STR_END;
          res.length = string_count;
          in_string_next = 1'b0;
        end
      end else if (in_string) begin
        res.valid = 1'b1;
        if (!full) begin
          res.kind = irec_pkg::EV_STR_CHAR;
          res.index = string_count;
          string_count_next = string_count + 1'b1;
        end else begin
          // Buffer full: the character is dropped and the string closes.
          res.kind = irec_pkg::EV_OVERFLOW;
          res.length = string_count;
          in_string_next = 1'b0;
        end
      end else begin
        res.valid = 1'b1;
        res.kind = irec_pkg::EV_LONE;
      end
    end
  end

  // String state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_string <= 1'b0;
      string_count <= '0;
    end else begin
      in_string <= in_string_next;
      string_count <= string_count_next;
    end
  end

endmodule

@@ src/ir_edge_timing_char_receiver.sv @@
// Channel  | Handshake                    | Payload
// ---------+------------------------------+---------------------------------------------
// input    | in_valid / in_ready          | edge_time, level_after
// output   | out_valid / out_ready        | event_kind, char_value, char_index,
//          |                              | string_length
// config   | cfg_we (no wait)             | cfg_index, cfg_data
//
// One edge is taken per cycle while the output does not stall; its result, if any, is
// registered in the input register and then in the output register. The edge timing and
// framing logic between those two registers updates the state.
// When the output stalls, one edge waits in the input register and in_ready drops.
// Reset is synchronous and returns the decoder to waiting for a start edge.
module ir_edge_timing_char_receiver (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [irec_pkg::TIMER_BITS-1:0]   edge_time,
  input  logic                              level_after,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [irec_pkg::KIND_W-1:0]       event_kind,
  output logic [irec_pkg::CHAR_W-1:0]       char_value,
  output logic [irec_pkg::COUNT_W-1:0]      char_index,
  output logic [irec_pkg::COUNT_W-1:0]      string_length,
  input  logic                              cfg_we,
  input  logic [irec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [irec_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam logic [irec_pkg::PHASE_W-1:0] PH_IDLE = 5'd0;
  localparam logic [irec_pkg::PHASE_W-1:0] PH_PERIOD = 5'd1;
  localparam logic [irec_pkg::PHASE_W-1:0] PH_ANCHOR = 5'd2;
  localparam int TW = irec_pkg::TIMER_BITS;

  // Configuration registers.
  logic [irec_pkg::BITCNT_W-1:0]  bit_count;
  logic [irec_pkg::CHAR_W-1:0]    start_code;
  logic [irec_pkg::CHAR_W-1:0]    end_code;

  // Input register.
  logic                           s1_valid;
  logic [TW-1:0]                  s1_time;
  logic                           s1_level;

  // Decoder state.
  logic [irec_pkg::PHASE_W-1:0]   edge_phase;
  logic [irec_pkg::PHASE_W-1:0]   edge_phase_next;
  logic [TW-1:0]                  last_edge_time;
  logic [TW-1:0]                  last_edge_time_next;
  logic [TW-1:0]                  half_period;
  logic [TW-1:0]                  half_period_next;
  logic [irec_pkg::MAX_BITS-1:0]  shift_word;
  logic [irec_pkg::MAX_BITS-1:0]  shift_word_next;

  logic                           proc;
  logic                           low;
  logic [TW-1:0]                  diff;
  logic                           late;
  logic [irec_pkg::BITCNT_W-1:0]  bits;
  logic [irec_pkg::PHASE_W:0]     stop_phase;
  logic                           char_strobe;
  irec_pkg::frame_res_t           res;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count <= irec_pkg::BIT_COUNT_RST;
      start_code <= irec_pkg::START_CODE_RST;
      end_code <= irec_pkg::END_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        irec_pkg::REG_BIT_COUNT:  bit_count <= cfg_data[irec_pkg::BITCNT_W-1:0];
        irec_pkg::REG_START_CODE: start_code <= cfg_data;
        irec_pkg::REG_END_CODE:   end_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // The input register advances whenever the output register can take a result.
  assign proc = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_time <= edge_time;
      s1_level <= level_after;
    end
  end

  // Edge timing: wrapped difference and the 1.5 half-period test as 2*diff > 3*period.
  assign low = !s1_level;
  assign diff = s1_time - last_edge_time;
  assign late = {1'b0, diff, 1'b0} > ({2'b00, half_period} + {1'b0, half_period, 1'b0});
  assign bits = (bit_count > irec_pkg::BITCNT_W'(irec_pkg::MAX_BITS))
                ? irec_pkg::BITCNT_W'(irec_pkg::MAX_BITS) : bit_count;
  assign stop_phase = {1'b0, bits} + (irec_pkg::PHASE_W+1)'(3);

  // Frame phase sequencing.
  always_comb begin
    edge_phase_next = edge_phase;
    last_edge_time_next = last_edge_time;
    half_period_next = half_period;
    shift_word_next = shift_word;
    char_strobe = 1'b0;
    if (proc) begin
      priority if (edge_phase == PH_IDLE) begin
        if (low) begin
          last_edge_time_next = s1_time;
          shift_word_next = '0;
          edge_phase_next = PH_PERIOD;
        end
      end else if (edge_phase == PH_PERIOD) begin
        half_period_next = diff;
        edge_phase_next = PH_ANCHOR;
      end else if (edge_phase == PH_ANCHOR) begin
        last_edge_time_next = s1_time;
        edge_phase_next = edge_phase + 1'b1;
      end else if ({1'b0, edge_phase} < stop_phase) begin
        // Data edge: a low level shifts in a one.
        if (late) begin
          shift_word_next = {shift_word[irec_pkg::MAX_BITS-2:0], low};
          last_edge_time_next = s1_time;
          edge_phase_next = edge_phase + 1'b1;
        end
      end else begin
        // Stop edge: the character is delivered only when the line ends high.
        if (late) begin
          last_edge_time_next = s1_time;
          edge_phase_next = PH_IDLE;
          char_strobe = !low;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_phase <= PH_IDLE;
      last_edge_time <= '0;
      half_period <= '0;
      shift_word <= '0;
    end else begin
      edge_phase <= edge_phase_next;
      last_edge_time <= last_edge_time_next;
      half_period <= half_period_next;
      shift_word <= shift_word_next;
    end
  end

  // String framing of delivered characters.
  irec_framer u_framer (
    .clk        (clk),
    .rst        (rst),
    .strobe     (char_strobe),
    .ch         (shift_word[irec_pkg::CHAR_W-1:0]),
    .start_code (start_code),
    .end_code   (end_code),
    .res        (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= proc && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res.valid) begin
      event_kind <= res.kind;
      char_value <= res.value;
      char_index <= res.index;
      string_length <= res.length;
    end
  end

  // The input side only stalls behind a result that is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without a waiting result");

  // The frame phase never runs past the stop edge of the longest frame.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    edge_phase <= irec_pkg::PHASE_W'(irec_pkg::MAX_BITS + 3))
    else $error("frame phase out of range");

  // A string never reports more characters than the buffer holds.
  a_length_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (string_length <= irec_pkg::COUNT_W'(irec_pkg::MAX_STRING)))
    else $error("string length beyond buffer size");

  // A string character always lands inside the buffer.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == irec_pkg::EV_STR_CHAR)
      |-> (char_index < irec_pkg::COUNT_W'(irec_pkg::MAX_STRING)))
    else $error("string character index beyond buffer");

  // Nothing is presented in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !out_valid)
    else $error("result presented straight after reset");

endmodule

@@ tb/irec_tb_pkg.sv @@
package irec_tb_pkg;

  import irec_pkg::*;

  // Decoder frame phases as the predictor counts them.
  localparam logic [PHASE_W-1:0] PH_IDLE = 5'd0;
  localparam logic [PHASE_W-1:0] PH_PERIOD = 5'd1;
  localparam logic [PHASE_W-1:0] PH_ANCHOR = 5'd2;

  // Register index that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // One framed character as it leaves the block.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CHAR_W-1:0]  value;
    logic [COUNT_W-1:0] index;
    logic [COUNT_W-1:0] length;
  } char_event_t;

  // Edge decoder and string framer, kept in step with every accepted edge.
  class char_event_board;
    logic [BITCNT_W-1:0]   bit_count;
    logic [CHAR_W-1:0]     start_code;
    logic [CHAR_W-1:0]     end_code;
    logic [PHASE_W-1:0]    frame_phase;
    logic [TIMER_BITS-1:0] last_time;
    logic [TIMER_BITS-1:0] half_period;
    logic [MAX_BITS-1:0]   shift_word;
    logic                  in_string;
    logic [COUNT_W-1:0]    string_count;
    char_event_t           expected_events[$];
    int                    errors;

    function new();
      bit_count = BIT_COUNT_RST;
      start_code = START_CODE_RST;
      end_code = END_CODE_RST;
      frame_phase = PH_IDLE;
      last_time = '0;
      half_period = '0;
      shift_word = '0;
      in_string = 1'b0;
      string_count = '0;
      errors = 0;
    endfunction

    // A bit count above the shift register width behaves as the full width.
    function int data_bits();
      return (bit_count > MAX_BITS) ? MAX_BITS : int'(bit_count);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BIT_COUNT: bit_count = data[BITCNT_W-1:0];
        REG_START_CODE: start_code = data;
        REG_END_CODE: end_code = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    function void push_event(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] value,
                             logic [COUNT_W-1:0] index, logic [COUNT_W-1:0] length);
      char_event_t ev;
      ev.kind = kind;
      ev.value = value;
      ev.index = index;
      ev.length = length;
      expected_events.push_back(ev);
    endfunction

    // String framing of a delivered character: start, characters, overflow, end or lone.
    function void frame_char(logic [CHAR_W-1:0] ch);
      if (ch == start_code) begin
        in_string = 1'b1;
        string_count = '0;
        push_event(EV_STR_START, ch, '0, '0);
      end else if (ch == end_code) begin
        if (in_string) begin
          in_string = 1'b0;
          push_event(EV_STR_END, ch, '0, string_count);
        end
      end else if (in_string) begin
        if (string_count < MAX_STRING) begin
          push_event(EV_STR_CHAR, ch, string_count, '0);
          string_count = string_count + 1'b1;
        end else begin
          // The buffer is full: the character is dropped and the string closes.
          in_string = 1'b0;
          push_event(EV_OVERFLOW, ch, '0, string_count);
        end
      end else begin
        push_event(EV_LONE, ch, '0, '0);
      end
    endfunction

    // Works out what one accepted edge does to the decoder state.
    function void take_edge(logic [TIMER_BITS-1:0] t, logic lvl);
      logic [TIMER_BITS-1:0] diff;
      logic                  late;
      int                    bits;
      bits = data_bits();
      diff = t - last_time;
      late = (2 * int'(diff)) > (3 * int'(half_period));
      if (frame_phase == PH_IDLE) begin
        if (!lvl) begin
          last_time = t;
          shift_word = '0;
          frame_phase = PH_PERIOD;
        end
      end else if (frame_phase == PH_PERIOD) begin
        half_period = diff;
        frame_phase = PH_ANCHOR;
      end else if (frame_phase == PH_ANCHOR) begin
        last_time = t;
        frame_phase = frame_phase + 1'b1;
      end else if (int'(frame_phase) < bits + 3) begin
        if (late) begin
          shift_word = {shift_word[MAX_BITS-2:0], !lvl};
          last_time = t;
          frame_phase = frame_phase + 1'b1;
        end
      end else if (late) begin
        last_time = t;
        frame_phase = PH_IDLE;
        if (lvl) frame_char(shift_word[CHAR_W-1:0]);
      end
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Compares one delivered event with the oldest one predicted.
    function void compare_event(char_event_t got);
      char_event_t want;
      if (expected_events.size() == 0) begin
        $error("event with nothing expected: kind %0d, char %0d", got.kind, got.value);
        errors++;
        return;
      end
      want = expected_events.pop_front();
      check_field("event_kind", want.kind, got.kind);
      check_field("char_value", want.value, got.value);
      check_field("char_index", want.index, got.index);
      check_field("string_length", want.length, got.length);
    endfunction
  endclass

endpackage

@@ tb/tb_top.sv @@
module tb_top;

  import irec_pkg::*;
  import irec_tb_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 150;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [TIMER_BITS-1:0] edge_time = '0;
  logic                  level_after = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [KIND_W-1:0]     event_kind;
  logic [CHAR_W-1:0]     char_value;
  logic [COUNT_W-1:0]    char_index;
  logic [COUNT_W-1:0]    string_length;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_BIT_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  char_event_board       board = new();
  logic [TIMER_BITS-1:0] cur_time = '0;
  int                    items_sent = 0;
  int                    quiet_cycles = 0;
  bit                    in_quiet = 1'b0;
  bit                    out_quiet = 1'b0;

  ir_edge_timing_char_receiver DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every delivered event is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.compare_event(char_event_t'({event_kind, char_value, char_index, string_length}));
  end

  // The run ends if neither channel moves a transaction for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver side: a random stall before each transaction.
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = out_quiet ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Offers one edge after a random gap and waits for its transaction.
  task automatic send_edge(input logic [TIMER_BITS-1:0] t, input logic lvl, input bit counts);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    edge_time <= t;
    level_after <= lvl;
    do @(posedge clk); while (!in_ready);
    board.take_edge(t, lvl);
    if (counts) items_sent++;
  endtask

  // Stops the sender, lets every predicted event arrive, then lets the pipe settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  // Bit count byte with random upper bits, which the register drops.
  function automatic logic [CFG_DATA_W-1:0] bit_count_byte(input int n);
    return {3'($urandom_range(0, 7)), 5'(n)};
  endfunction

  // Spacing of a full bit: about two half periods, always late enough.
  function automatic int unsigned bit_gap(input int unsigned p);
    int unsigned d;
    d = 2 * p + $urandom_range(0, p / 4) - $urandom_range(0, p / 4);
    return (d == 0) ? 1 : d;
  endfunction

  // Mostly short periods, a few zero or tiny ones and a few that wrap the timer.
  function automatic int unsigned pick_period();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(0, 1);
    if (r == 1) return $urandom_range(5000, 20000);
    return $urandom_range(2, 300);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return board.start_code;
    if (r == 1) return board.end_code;
    return 8'($urandom_range(0, 255));
  endfunction

  // Brings the decoder back to waiting for a start edge with late high edges.
  task automatic resync();
    while (board.frame_phase != PH_IDLE) begin
      if (board.frame_phase == PH_PERIOD)
        cur_time = board.last_time + 16'($urandom_range(1, 200));
      else
        cur_time = board.last_time + 16'((3 * int'(board.half_period)) / 2 + 1);
      send_edge(cur_time, 1'b1, 1'b1);
    end
  endtask

  // One well-formed frame: start, period, anchor, data bits and stop, with optional
  // mid-bit edges that fail the timing test.
  task automatic send_frame(input logic [CHAR_W-1:0] ch, input int unsigned p,
                            input logic stop_lvl, input int mid_pct);
    int bits;
    resync();
    bits = board.data_bits();
    cur_time += 16'($urandom_range(1, 3000));
    send_edge(cur_time, 1'b0, 1'b1);
    cur_time += 16'(p);
    send_edge(cur_time, 1'($urandom_range(0, 1)), 1'b1);
    cur_time += 16'(bit_gap(p));
    send_edge(cur_time, 1'($urandom_range(0, 1)), 1'b1);
    for (int i = bits; i >= 0; i--) begin
      if ($urandom_range(0, 99) < mid_pct)
        send_edge(cur_time + 16'($urandom_range(0, p)), 1'($urandom_range(0, 1)), 1'b1);
      cur_time += 16'(bit_gap(p));
      if (i == 0)
        send_edge(cur_time, stop_lvl, 1'b1);
      else if (i - 1 < CHAR_W)
        send_edge(cur_time, !ch[i-1], 1'b1);
      else
        send_edge(cur_time, 1'($urandom_range(0, 1)), 1'b1);
    end
  endtask

  function automatic logic random_stop();
    return $urandom_range(0, 11) != 0;
  endfunction

  // A string: its start code, a run of characters that may overflow, and mostly an end.
  task automatic send_text_run();
    send_frame(board.start_code, pick_period(), 1'b1, 40);
    repeat ($urandom_range(0, 13))
      send_frame(8'($urandom_range(0, 255)), pick_period(), random_stop(), 40);
    if ($urandom_range(0, 9) < 7)
      send_frame(board.end_code, pick_period(), 1'b1, 40);
  endtask

  // Register settings for each random phase; the first few are the extremes.
  task automatic configure(input int k);
    int n;
    int eff;
    logic [CHAR_W-1:0] mask;
    case (k)
      0: begin
        cfg_write(REG_BIT_COUNT, bit_count_byte(16));
        cfg_write(REG_START_CODE, 8'h00);
        cfg_write(REG_END_CODE, 8'hFF);
      end
      1: begin
        cfg_write(REG_BIT_COUNT, bit_count_byte(1));
        cfg_write(REG_START_CODE, 8'h00);
        cfg_write(REG_END_CODE, 8'h01);
      end
      2: begin
        // No data bits: every delivered character is zero.
        cfg_write(REG_BIT_COUNT, bit_count_byte(0));
        cfg_write(REG_START_CODE, 8'h55);
        cfg_write(REG_END_CODE, 8'hAA);
      end
      3: begin
        // Oversized bit count, and start and end codes that coincide.
        cfg_write(REG_BIT_COUNT, 8'hFF);
        cfg_write(REG_START_CODE, 8'h80);
        cfg_write(REG_END_CODE, 8'h80);
      end
      4: begin
        cfg_write(REG_UNUSED, 8'($urandom_range(0, 255)));
        cfg_write(REG_BIT_COUNT, bit_count_byte(4));
        cfg_write(REG_START_CODE, 8'h0F);
        cfg_write(REG_END_CODE, 8'h00);
      end
      default: begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 31) : $urandom_range(1, 16);
        eff = (n > MAX_BITS) ? MAX_BITS : n;
        mask = (eff >= CHAR_W) ? 8'hFF : 8'((1 << eff) - 1);
        cfg_write(REG_BIT_COUNT, bit_count_byte(n));
        cfg_write(REG_START_CODE, 8'($urandom_range(0, 255)) & mask);
        cfg_write(REG_END_CODE, 8'($urandom_range(0, 255)) & mask);
      end
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Main sequence: reset, directed frames, then random phases under several settings.
  initial begin
    int r;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    cur_time = 16'hF000;
    // A high edge while waiting for a start is ignored.
    send_edge(cur_time, 1'b1, 1'b0);
    // A long period carries the timer through its wrap; an end code outside a string.
    send_frame(END_CODE_RST, 20000, 1'b1, 0);
    // A zero period makes every later edge late; all-ones character.
    send_frame(8'hFF, 0, 1'b1, 0);

    for (int k = 0; k < PHASES; k++) begin
      wait_idle();
      in_quiet = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      configure(k);
      while (items_sent < (k + 1) * ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          // Noise: edges at arbitrary spacing that break or start frames.
          repeat ($urandom_range(1, 3)) begin
            cur_time += 16'($urandom_range(0, 4000));
            send_edge(cur_time, 1'($urandom_range(0, 1)), 1'b1);
          end
        end else if (r < 40) begin
          send_text_run();
        end else begin
          send_frame(pick_char(), pick_period(), random_stop(), 40);
        end
      end
    end

    wait_idle();
    if (board.errors == 0 && board.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
